FILE: rtl/core/let_pkg.sv
// ----------------------------------------------------------------------------
// let_pkg: shared types and constants of the line end extension tracker
// Holds the controller state encoding, the command and status structs
// exchanged between controller and datapath, and fixed constants.
// ----------------------------------------------------------------------------
package let_pkg;

  // Register indexes of the configuration port.
  localparam logic [1:0] CFG_GAP_LIMIT   = 2'd0;
  localparam logic [1:0] CFG_CONS_MIN    = 2'd1;
  localparam logic [1:0] CFG_TELE_PCT    = 2'd2;
  localparam logic [1:0] CFG_BRIDGE_LIM  = 2'd3;

  // Slope limit of the window shift accumulator.
  localparam int SHIFT_DIST = 15;
  // Divisor of the telescope percentage.
  localparam int PCT_DIV = 100;
  // Width of the pixel field of one column.
  localparam int PIXEL_BITS = 5;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COUNT,
    ST_SCAN,
    ST_TRACK,
    ST_STEP,
    ST_CHECK,
    ST_OUT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_start;   // latch a start request
    logic do_count;     // update streaks and counters
    logic scan_en;      // examine one streak counter
    logic do_track;     // window tracking update
    logic do_step;      // compute and apply the step
    logic do_check;     // evaluate the bridge limit
    logic finish_idle;  // column without a running job or with a read error
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic gap_stop;   // gap limit exceeded on this column
    logic scan_last;  // last streak counter examined
  } stat_t;

endpackage

FILE: rtl/core/line_end_extension_tracker.sv
// ----------------------------------------------------------------------------
// line_end_extension_tracker: extends one line end through a binary image
// Top level joining the sequencer, the datapath and the register file.
// ----------------------------------------------------------------------------
// Usage: a start request (in_action 0) loads the line end, edges, track
// center and direction; each column request (in_action 1) carries the black
// flags of the scan window or a read error. Every request yields exactly one
// result on the out_ channel with the next read position and the line.
// Sequence: a start or an idle/error column goes straight to the result
// state; a column that exceeds the gap limit ends after the count step; any
// other column runs the count step, the serial search over the streak
// counters, one counter per cycle, then the track, step and check steps.
// One request is in work at a time; the next is accepted in the cycle after
// the result has been taken. While the receiver holds out_ready low the
// result stays stable and no new request is taken. Synchronous reset clears
// the job and restores the register defaults (gap 20, minimum 20, percent
// 35, bridge 100). Configuration writes are taken at any edge with cfg_we
// high.
// ----------------------------------------------------------------------------
module line_end_extension_tracker #(
  parameter int SCAN_LINES = 5
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [9:0]         cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_action,
  input  logic signed [15:0] in_end_position,
  input  logic signed [15:0] in_edge_low,
  input  logic signed [15:0] in_edge_high,
  input  logic signed [15:0] in_initial_center,
  input  logic               in_direction_up,
  input  logic [4:0]         in_pixel_bits,
  input  logic               in_read_error,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_read_length_position,
  output logic signed [15:0] out_read_window_edge,
  output logic signed [15:0] out_new_end_position,
  output logic signed [15:0] out_new_edge_low,
  output logic signed [15:0] out_new_edge_high,
  output logic               out_extended,
  output logic               out_done_res
);

  logic [7:0] gap_limit_r, cons_min_r, tele_pct_r;
  logic [9:0] bridge_limit_r;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_limit_r    <= 8'd20;
      cons_min_r     <= 8'd20;
      tele_pct_r     <= 8'd35;
      bridge_limit_r <= 10'd100;
    end else if (cfg_we) begin
      case (cfg_index)
        let_pkg::CFG_GAP_LIMIT:  gap_limit_r    <= cfg_data[7:0];
        let_pkg::CFG_CONS_MIN:   cons_min_r     <= cfg_data[7:0];
        let_pkg::CFG_TELE_PCT:   tele_pct_r     <= cfg_data[7:0];
        let_pkg::CFG_BRIDGE_LIM: bridge_limit_r <= cfg_data;
        default: ;
      endcase
    end
  end

  let_pkg::cmd_t  cmd;
  let_pkg::stat_t stat;

  let_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .in_action, .in_read_error,
    .out_valid, .out_ready, .done_now(out_done_res), .cmd, .stat
  );

  let_datapath #(.SCAN_LINES(SCAN_LINES)) u_dp (
    .clk, .rst_n, .cmd, .stat,
    .gap_limit(gap_limit_r), .cons_min(cons_min_r), .tele_pct(tele_pct_r),
    .bridge_limit(bridge_limit_r),
    .in_end_position, .in_edge_low, .in_edge_high, .in_initial_center,
    .in_direction_up, .in_pixel_bits,
    .done_o(out_done_res), .pos_o(out_read_length_position),
    .wedge_o(out_read_window_edge), .end_o(out_new_end_position),
    .elow_o(out_new_edge_low), .ehigh_o(out_new_edge_high), .ext_o(out_extended)
  );

endmodule

FILE: rtl/core/let_datapath.sv
// ----------------------------------------------------------------------------
// let_datapath: registers and arithmetic of the line end extension tracker
// Holds the job state, the streak counters and the result register, and
// executes one step of the column update for each controller command.
// ----------------------------------------------------------------------------
module let_datapath #(
  parameter int SCAN_LINES = 5
) (
  input  logic               clk,
  input  logic               rst_n,
  input  let_pkg::cmd_t      cmd,
  output let_pkg::stat_t     stat,
  input  logic [7:0]         gap_limit,
  input  logic [7:0]         cons_min,
  input  logic [7:0]         tele_pct,
  input  logic [9:0]         bridge_limit,
  input  logic signed [15:0] in_end_position,
  input  logic signed [15:0] in_edge_low,
  input  logic signed [15:0] in_edge_high,
  input  logic signed [15:0] in_initial_center,
  input  logic               in_direction_up,
  input  logic [4:0]         in_pixel_bits,
  output logic               done_o,
  output logic signed [15:0] pos_o,
  output logic signed [15:0] wedge_o,
  output logic signed [15:0] end_o,
  output logic signed [15:0] elow_o,
  output logic signed [15:0] ehigh_o,
  output logic               ext_o
);

  localparam int IW   = (SCAN_LINES > 1) ? $clog2(SCAN_LINES) : 1;
  localparam int HALF = SCAN_LINES / 2;
  localparam logic [15:0] HALF16 = 16'(HALF);
  localparam int PIXEL_BITS_C = let_pkg::PIXEL_BITS;
  // Rounded-up reciprocal of 100 scaled by 2^31.
  localparam logic [24:0] RECIP100 = 25'd21474837;

  logic [15:0] streak_r [SCAN_LINES];
  logic [15:0] streak_nxt [SCAN_LINES];
  logic [15:0] pos_r, wedge_r, center_r, step_r, gap_r, cons_r;
  logic [15:0] end_r, elow_r, ehigh_r;
  logic signed [3:0] tshift_r;
  logic signed [7:0] acc_r;
  logic up_r, ext_r, found_r, gstop_r;
  logic [IW-1:0] scan_i_r;
  logic [15:0] best_r;
  logic [IW-1:0] best_i_r;
  logic [23:0] prod_r;

  // Streak counter at the tracked center, zero if outside the window.
  logic [15:0] cidx;
  logic [15:0] at_center;
  always_comb begin
    cidx = center_r - wedge_r;
    at_center = '0;
    if (cidx < 16'(SCAN_LINES)) begin
      at_center = streak_r[cidx[IW-1:0]];
    end
  end

  assign stat.gap_stop  = gstop_r;
  assign stat.scan_last = (scan_i_r == IW'(SCAN_LINES - 1));

  // Per scan line streak update and the column counters.
  logic any_black;
  logic [15:0] gap_inc;
  logic [15:0] cons_v, gap_v;
  logic stop_v;
  always_comb begin
    any_black = 1'b0;
    for (int i = 0; i < SCAN_LINES; i++) begin
      if (i < PIXEL_BITS_C && in_pixel_bits[i % 5]) begin
        streak_nxt[i] = (streak_r[i] == 16'hFFFF) ? streak_r[i] : streak_r[i] + 16'd1;
        any_black = 1'b1;
      end else begin
        streak_nxt[i] = '0;
      end
    end
    gap_inc = (gap_r == 16'hFFFF) ? gap_r : gap_r + 16'd1;
    cons_v  = any_black ? ((cons_r == 16'hFFFF) ? cons_r : cons_r + 16'd1) : 16'd0;
    gap_v   = any_black ? gap_r : gap_inc;
    stop_v  = !any_black && (gap_v > {8'd0, gap_limit});
  end

  // Step distance for the next column and the telescope product.
  logic [15:0] step_nxt;
  logic [15:0] adv;
  assign step_nxt = found_r ? 16'd1 : ((step_r == 16'hFFFF) ? step_r : step_r + 16'd1);
  // Division by 100 as a reciprocal multiply; exact for every product below 2^24.
  logic [48:0] q_mul;
  logic [17:0] quo;
  always_comb begin
    q_mul = 49'(prod_r) * 49'(RECIP100);
    quo   = q_mul[48:31];
    adv   = (quo == 18'd0) ? 16'd1 : quo[15:0];
  end

  // Bridge check arithmetic in 18 bits signed.
  logic signed [17:0] beyond;
  always_comb begin
    if (up_r) begin
      beyond = 18'(signed'(pos_r)) - 18'(signed'(end_r)) - signed'({2'b0, cons_r});
    end else begin
      beyond = 18'(signed'(end_r)) - 18'(signed'(pos_r)) - signed'({2'b0, cons_r});
    end
  end

  logic signed [15:0] mid;
  assign mid = signed'(wedge_r + HALF16);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SCAN_LINES; i++) streak_r[i] <= '0;
      pos_r <= '0; wedge_r <= '0; center_r <= '0; step_r <= '0;
      gap_r <= '0; cons_r <= '0; end_r <= '0; elow_r <= '0; ehigh_r <= '0;
      tshift_r <= '0; acc_r <= '0; up_r <= 1'b0; ext_r <= 1'b0;
      found_r <= 1'b0; gstop_r <= 1'b0; scan_i_r <= '0; best_r <= '0;
      best_i_r <= '0; prod_r <= '0; done_o <= 1'b0;
    end else begin
      if (cmd.load_start) begin
        for (int i = 0; i < SCAN_LINES; i++) streak_r[i] <= '0;
        end_r    <= in_end_position;
        pos_r    <= in_end_position;
        elow_r   <= in_edge_low;
        ehigh_r  <= in_edge_high;
        wedge_r  <= in_initial_center - HALF16;
        center_r <= in_initial_center;
        tshift_r <= '0; acc_r <= '0; step_r <= '0; gap_r <= '0; cons_r <= '0;
        up_r     <= in_direction_up;
        ext_r    <= 1'b0;
        done_o   <= 1'b0;
      end
      if (cmd.finish_idle) begin
        done_o <= 1'b1;
      end
      // Column counters and extension acceptance.
      if (cmd.do_count) begin
        for (int i = 0; i < SCAN_LINES; i++) streak_r[i] <= streak_nxt[i];
        found_r  <= any_black;
        scan_i_r <= '0;
        best_r   <= '0;
        best_i_r <= '0;
        gstop_r  <= stop_v;
        done_o   <= stop_v;
        cons_r   <= cons_v;
        if (!stop_v && cons_v >= {8'd0, cons_min}) begin
          gap_r <= '0;
          end_r <= pos_r;
          if (mid < signed'(elow_r)) begin
            elow_r <= mid;
          end else if (mid > signed'(ehigh_r)) begin
            ehigh_r <= mid;
          end
          ext_r <= 1'b1;
        end else begin
          gap_r <= gap_v;
        end
      end
      // Search for the longest streak, one counter per cycle.
      if (cmd.scan_en) begin
        if (streak_r[scan_i_r] > best_r) begin
          best_r   <= streak_r[scan_i_r];
          best_i_r <= scan_i_r;
        end
        if (scan_i_r != IW'(SCAN_LINES - 1)) begin
          scan_i_r <= scan_i_r + IW'(1);
        end
      end
      // Retarget, then shift the window at most one row.
      if (cmd.do_track) begin
        logic signed [3:0] ts;
        logic [15:0] cen;
        ts  = tshift_r;
        cen = center_r;
        if (found_r && at_center == 16'd0 && best_r != 16'd0) begin
          cen = wedge_r + 16'(best_i_r);
          ts  = 4'(signed'({1'b0, best_i_r}) - HALF);
        end
        if (ts != 0) begin
          logic sp;
          logic signed [8:0] a;
          sp = (ts > 0);
          a  = sp ? 9'(acc_r) + 9'sd1 : 9'(acc_r) - 9'sd1;
          if ((a == 0) || ((a > 0) == sp)) begin
            a = sp ? a - 9'(let_pkg::SHIFT_DIST) : a + 9'(let_pkg::SHIFT_DIST);
            wedge_r <= sp ? wedge_r + 16'd1 : wedge_r - 16'd1;
            cen     = sp ? cen + 16'd1 : cen - 16'd1;
            ts      = sp ? ts - 4'sd1 : ts + 4'sd1;
            if (sp) begin
              for (int i = 0; i < SCAN_LINES - 1; i++) streak_r[i] <= streak_r[i+1];
              streak_r[SCAN_LINES-1] <= '0;
            end else begin
              for (int i = SCAN_LINES - 1; i > 0; i--) streak_r[i] <= streak_r[i-1];
              streak_r[0] <= '0;
            end
          end
          acc_r <= a[7:0];
        end
        center_r <= cen;
        tshift_r <= ts;
        step_r   <= step_nxt;
        prod_r   <= 24'(step_nxt) * 24'(tele_pct);
      end
      // Advance the read position by the telescoped step.
      if (cmd.do_step) begin
        pos_r <= up_r ? pos_r + adv : pos_r - adv;
      end
      if (cmd.do_check) begin
        if (beyond > signed'({8'd0, bridge_limit})) begin
          done_o <= 1'b1;
        end
      end
    end
  end

  assign pos_o   = pos_r;
  assign wedge_o = wedge_r;
  assign end_o   = end_r;
  assign elow_o  = elow_r;
  assign ehigh_o = ehigh_r;
  assign ext_o   = ext_r;

endmodule

FILE: rtl/core/let_ctrl.sv
// ----------------------------------------------------------------------------
// let_ctrl: sequencer of the line end extension tracker
// Accepts requests, runs the datapath through the column steps and holds
// the result until the receiver takes it.
// ----------------------------------------------------------------------------
module let_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic           in_action,
  input  logic           in_read_error,
  output logic           out_valid,
  input  logic           out_ready,
  input  logic           done_now,
  output let_pkg::cmd_t  cmd,
  input  let_pkg::stat_t stat
);

  let_pkg::state_t state_r, state_nxt;
  logic active_r, active_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= let_pkg::ST_IDLE;
      active_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      active_r <= active_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt  = state_r;
    active_nxt = active_r;
    cmd        = '0;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    case (state_r)
      let_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (!in_action) begin
            cmd.load_start = 1'b1;
            active_nxt     = 1'b1;
            state_nxt      = let_pkg::ST_OUT;
          end else if (!active_r || in_read_error) begin
            cmd.finish_idle = 1'b1;
            active_nxt      = 1'b0;
            state_nxt       = let_pkg::ST_OUT;
          end else begin
            cmd.do_count = 1'b1;
            state_nxt    = let_pkg::ST_COUNT;
          end
        end
      end
      let_pkg::ST_COUNT: begin
        if (stat.gap_stop) begin
          active_nxt = 1'b0;
          state_nxt  = let_pkg::ST_OUT;
        end else begin
          state_nxt = let_pkg::ST_SCAN;
        end
      end
      let_pkg::ST_SCAN: begin
        cmd.scan_en = 1'b1;
        if (stat.scan_last) state_nxt = let_pkg::ST_TRACK;
      end
      let_pkg::ST_TRACK: begin
        cmd.do_track = 1'b1;
        state_nxt    = let_pkg::ST_STEP;
      end
      let_pkg::ST_STEP: begin
        cmd.do_step = 1'b1;
        state_nxt   = let_pkg::ST_CHECK;
      end
      let_pkg::ST_CHECK: begin
        cmd.do_check = 1'b1;
        state_nxt    = let_pkg::ST_OUT;
      end
      let_pkg::ST_OUT: begin
        out_valid = 1'b1;
        if (done_now) active_nxt = 1'b0;
        if (out_ready) state_nxt = let_pkg::ST_IDLE;
      end
      default: state_nxt = let_pkg::ST_IDLE;
    endcase
  end

  // A result is only offered while no request is being taken.
  assert property (@(posedge clk) disable iff (!rst_n) !(out_valid && in_ready))
    else $error("result offered while accepting");
  // A start request always leads to the result state.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && !in_action) |=> (state_r == let_pkg::ST_OUT))
    else $error("start did not produce a result");
  // After a gap stop the job is no longer active.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == let_pkg::ST_COUNT && stat.gap_stop) |=> !active_r)
    else $error("job active after gap stop");

endmodule

FILE: test/let_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// let_checker: result predictor and comparator for the line end tracker
// Watches both request channels, models the extension job per request and
// compares every result field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module let_checker #(
  parameter int SCAN_LINES = 5
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [9:0]         cfg_data,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic               in_action,
  input  logic signed [15:0] in_end_position,
  input  logic signed [15:0] in_edge_low,
  input  logic signed [15:0] in_edge_high,
  input  logic signed [15:0] in_initial_center,
  input  logic               in_direction_up,
  input  logic [4:0]         in_pixel_bits,
  input  logic               in_read_error,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [15:0] out_read_length_position,
  input  logic signed [15:0] out_read_window_edge,
  input  logic signed [15:0] out_new_end_position,
  input  logic signed [15:0] out_new_edge_low,
  input  logic signed [15:0] out_new_edge_high,
  input  logic               out_extended,
  input  logic               out_done_res,
  output int                 fail_count,
  output int                 pending_count
);

  localparam int EXP_DEPTH = 8;

  typedef struct packed {
    logic [15:0] rd_pos;
    logic [15:0] rd_edge;
    logic [15:0] end_pos;
    logic [15:0] edge_lo;
    logic [15:0] edge_hi;
    logic        ext;
    logic        done;
  } line_result_t;

  // Expected results in request order.
  line_result_t exp_store[EXP_DEPTH];
  int           wr_cnt, rd_cnt;

  // Register copies.
  logic [7:0] gap_lim, cons_min, tele_pct;
  logic [9:0] bridge_lim;

  // Job state.
  logic [15:0] streak[SCAN_LINES];
  logic [15:0] len_pos, win_edge, center, step_dist, gaps, cons;
  logic [15:0] end_pos, edge_lo, edge_hi;
  int          tgt_shift, shift_acc;
  logic        active, dir_up, ext;

  function automatic logic [15:0] sat_inc(logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  // Steer the window toward the longest streak, one row per allowed slope.
  function automatic void steer_window(bit found);
    logic [15:0] idx, at_center, best;
    int          best_i, sgn, acc;
    bit          move;
    idx = center - win_edge;
    at_center = (idx < SCAN_LINES) ? streak[idx] : 16'd0;
    if (found && at_center == 0) begin
      best = 0;
      best_i = 0;
      for (int i = 0; i < SCAN_LINES; i++) begin
        if (streak[i] > best) begin
          best = streak[i];
          best_i = i;
        end
      end
      if (best > 0) begin
        center = win_edge + 16'(best_i);
        tgt_shift = best_i - SCAN_LINES / 2;
      end
    end
    if (tgt_shift != 0) begin
      sgn = (tgt_shift > 0) ? 1 : -1;
      acc = shift_acc + sgn;
      move = (acc == 0) ? 1'b1 : (((acc > 0) ? 1 : -1) == sgn);
      if (move) begin
        acc -= let_pkg::SHIFT_DIST * sgn;
        win_edge = win_edge + 16'(sgn);
        center = center + 16'(sgn);
        tgt_shift -= sgn;
        if (sgn == 1) begin
          for (int i = 0; i + 1 < SCAN_LINES; i++) streak[i] = streak[i + 1];
          streak[SCAN_LINES - 1] = 0;
        end else begin
          for (int i = SCAN_LINES - 1; i > 0; i--) streak[i] = streak[i - 1];
          streak[0] = 0;
        end
      end
      shift_acc = int'($signed(8'(acc)));
    end
  endfunction

  // One scanned column; returns 1 when the job ends on it.
  function automatic bit scan_column(logic [4:0] bits);
    bit          found;
    logic [31:0] adv;
    logic [15:0] mid;
    int          beyond;
    found = 0;
    for (int i = 0; i < SCAN_LINES; i++) begin
      if (i < let_pkg::PIXEL_BITS && bits[i]) begin
        streak[i] = sat_inc(streak[i]);
        found = 1;
      end else begin
        streak[i] = 0;
      end
    end
    if (found) begin
      cons = sat_inc(cons);
    end else begin
      gaps = sat_inc(gaps);
      cons = 0;
      if (gaps > gap_lim) return 1;
    end
    if (cons >= cons_min) begin
      mid = win_edge + 16'(SCAN_LINES / 2);
      gaps = 0;
      end_pos = len_pos;
      if ($signed(mid) < $signed(edge_lo)) edge_lo = mid;
      else if ($signed(mid) > $signed(edge_hi)) edge_hi = mid;
      ext = 1;
    end
    steer_window(found);
    step_dist = found ? 16'd1 : sat_inc(step_dist);
    adv = 32'(step_dist) * 32'(tele_pct) / let_pkg::PCT_DIV;
    if (adv < 1) adv = 1;
    if (dir_up) begin
      len_pos = len_pos + adv[15:0];
      beyond = int'($signed(len_pos)) - int'($signed(end_pos)) - int'(cons);
    end else begin
      len_pos = len_pos - adv[15:0];
      beyond = int'($signed(end_pos)) - int'($signed(len_pos)) - int'(cons);
    end
    return beyond > int'(bridge_lim);
  endfunction

  // Predict the result of one accepted request.
  task automatic predict_request();
    bit           finished;
    line_result_t r;
    finished = 0;
    if (!in_action) begin
      foreach (streak[i]) streak[i] = 0;
      end_pos = in_end_position;
      edge_lo = in_edge_low;
      edge_hi = in_edge_high;
      win_edge = in_initial_center - 16'(SCAN_LINES / 2);
      center = win_edge + 16'(SCAN_LINES / 2);
      len_pos = in_end_position;
      tgt_shift = 0;
      shift_acc = 0;
      step_dist = 0;
      gaps = 0;
      cons = 0;
      active = 1;
      dir_up = in_direction_up;
      ext = 0;
    end else if (!active || in_read_error) begin
      finished = 1;
    end else begin
      finished = scan_column(in_pixel_bits);
    end
    if (finished) active = 0;
    r = '{len_pos, win_edge, end_pos, edge_lo, edge_hi, ext, finished};
    exp_store[wr_cnt % EXP_DEPTH] = r;
    wr_cnt++;
  endtask

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    $display("%0t: %s mismatch: got %0h, expected %0h", $realtime, what, got, want);
    fail_count++;
  endtask

  // Compare one accepted result with the oldest prediction.
  task automatic check_result();
    line_result_t w;
    if (wr_cnt == rd_cnt) begin
      $display("%0t: result with no request outstanding", $realtime);
      fail_count++;
      return;
    end
    w = exp_store[rd_cnt % EXP_DEPTH];
    rd_cnt++;
    if (out_read_length_position !== w.rd_pos)
      report_mismatch("read_length_position", out_read_length_position, w.rd_pos);
    if (out_read_window_edge !== w.rd_edge)
      report_mismatch("read_window_edge", out_read_window_edge, w.rd_edge);
    if (out_new_end_position !== w.end_pos)
      report_mismatch("new_end_position", out_new_end_position, w.end_pos);
    if (out_new_edge_low !== w.edge_lo)
      report_mismatch("new_edge_low", out_new_edge_low, w.edge_lo);
    if (out_new_edge_high !== w.edge_hi)
      report_mismatch("new_edge_high", out_new_edge_high, w.edge_hi);
    if (out_extended !== w.ext)
      report_mismatch("extended", 16'(out_extended), 16'(w.ext));
    if (out_done_res !== w.done)
      report_mismatch("done_res", 16'(out_done_res), 16'(w.done));
  endtask

  initial begin
    fail_count = 0;
    wr_cnt = 0;
    rd_cnt = 0;
  end

  assign pending_count = wr_cnt - rd_cnt;

  // Track registers, requests and results at every rising edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      gap_lim = 8'd20;
      cons_min = 8'd20;
      tele_pct = 8'd35;
      bridge_lim = 10'd100;
      foreach (streak[i]) streak[i] = 0;
      {len_pos, win_edge, center, step_dist, gaps, cons} = '0;
      {end_pos, edge_lo, edge_hi} = '0;
      tgt_shift = 0;
      shift_acc = 0;
      {active, dir_up, ext} = '0;
      wr_cnt = 0;
      rd_cnt = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          let_pkg::CFG_GAP_LIMIT:  gap_lim = cfg_data[7:0];
          let_pkg::CFG_CONS_MIN:   cons_min = cfg_data[7:0];
          let_pkg::CFG_TELE_PCT:   tele_pct = cfg_data[7:0];
          let_pkg::CFG_BRIDGE_LIM: bridge_lim = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && out_ready) check_result();
      if (in_valid && in_ready) predict_request();
    end
  end

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: regression of the line end extension tracker
// Drives directed and random extension jobs with random gaps on both sides,
// walks the registers through several settings, and gives the verdict from
// the checker's failure count.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int SCAN_LINES = 5;
  localparam int DRAIN_CYCLES = 40;

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic [1:0]         cfg_index;
  logic [9:0]         cfg_data;
  logic               in_valid;
  logic               in_ready;
  logic               in_action;
  logic signed [15:0] in_end_position;
  logic signed [15:0] in_edge_low;
  logic signed [15:0] in_edge_high;
  logic signed [15:0] in_initial_center;
  logic               in_direction_up;
  logic [4:0]         in_pixel_bits;
  logic               in_read_error;
  logic               out_valid;
  logic               out_ready;
  logic signed [15:0] out_read_length_position;
  logic signed [15:0] out_read_window_edge;
  logic signed [15:0] out_new_end_position;
  logic signed [15:0] out_new_edge_low;
  logic signed [15:0] out_new_edge_high;
  logic               out_extended;
  logic               out_done_res;
  int                 fail_count;
  int                 pending_count;

  line_end_extension_tracker #(.SCAN_LINES(SCAN_LINES)) dut (.*);

  let_checker #(.SCAN_LINES(SCAN_LINES)) u_checker (.*);

  // Clock.
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Run limit.
  initial begin
    #5ms;
    $display("line_end_extension_tracker regression: fail");
    $finish;
  end

  // Receiver: random stall before taking each result.
  initial begin
    out_ready = 1'b0;
    @(negedge clk);
    forever begin
      repeat ($urandom_range(0, 7)) @(negedge clk);
      out_ready = 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      @(negedge clk);
      out_ready = 1'b0;
    end
  end

  // Send one request after a random gap; returns at the falling edge after it.
  task automatic send_request(bit act, logic [15:0] endp, logic [15:0] lo,
                              logic [15:0] hi, logic [15:0] ctr, bit up,
                              logic [4:0] bits, bit rerr);
    repeat ($urandom_range(0, 7)) @(negedge clk);
    in_action = act;
    in_end_position = endp;
    in_edge_low = lo;
    in_edge_high = hi;
    in_initial_center = ctr;
    in_direction_up = up;
    in_pixel_bits = bits;
    in_read_error = rerr;
    in_valid = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic start_job(logic [15:0] endp, logic [15:0] ctr, bit up);
    send_request(1'b0, endp, endp - 16'(3), endp + 16'(3), ctr, up,
                 5'($urandom), 1'($urandom));
  endtask

  task automatic send_column(logic [4:0] bits, bit rerr);
    send_request(1'b1, 16'($urandom), 16'($urandom), 16'($urandom),
                 16'($urandom), 1'($urandom), bits, rerr);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [9:0] val);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Wait until every result has arrived and the block is quiet.
  task automatic settle();
    while (pending_count != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // One well-formed job: start, then mostly black columns with gaps.
  task automatic random_job(int cols);
    logic [4:0] row_bits;
    start_job(16'($urandom), 16'($urandom), 1'($urandom));
    row_bits = 5'b00100;
    for (int i = 0; i < cols; i++) begin
      case ($urandom_range(0, 9))
        0:       send_column(5'd0, 1'b0);
        1:       row_bits = 5'($urandom);
        2:       row_bits = (row_bits << 1) | 5'd1;
        3:       row_bits = row_bits >> 1;
        default: ;
      endcase
      send_column(row_bits, ($urandom_range(0, 99) == 0));
    end
  endtask

  task automatic set_regs(logic [7:0] g, logic [7:0] c, logic [7:0] p, logic [9:0] b);
    settle();
    write_reg(let_pkg::CFG_GAP_LIMIT, 10'(g));
    write_reg(let_pkg::CFG_CONS_MIN, 10'(c));
    write_reg(let_pkg::CFG_TELE_PCT, 10'(p));
    write_reg(let_pkg::CFG_BRIDGE_LIM, b);
  endtask

  // Stimulus.
  initial begin
    int sent;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_action = 1'b0;
    in_end_position = '0;
    in_edge_low = '0;
    in_edge_high = '0;
    in_initial_center = '0;
    in_direction_up = 1'b0;
    in_pixel_bits = '0;
    in_read_error = 1'b0;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed: column while idle, extremes, read error, gap stop.
    send_column(5'b11111, 1'b0);
    start_job(16'sh7FFE, 16'sh7FFF, 1'b1);
    send_column(5'b11111, 1'b0);
    send_column(5'b10000, 1'b0);
    send_column(5'b00001, 1'b0);
    send_column(5'b00000, 1'b0);
    send_column(5'b00100, 1'b1);
    send_column(5'b00100, 1'b0);
    start_job(16'sh8001, 16'sh8000, 1'b0);
    repeat (3) send_column(5'b00000, 1'b0);
    set_regs(8'd0, 8'd0, 8'd255, 10'd1023);
    start_job(16'd0, 16'd0, 1'b1);
    send_column(5'b00000, 1'b0);
    start_job(16'd100, 16'd2, 1'b0);
    repeat (5) send_column(5'b00001, 1'b0);
    send_column(5'b00000, 1'b0);
    set_regs(8'd255, 8'd1, 8'd0, 10'd0);
    start_job(16'd10, 16'hFFFF, 1'b1);
    repeat (4) send_column(5'b11000, 1'b0);

    // Random jobs across register settings.
    sent = 0;
    while (sent < 500) begin
      if ($urandom_range(0, 5) == 0) begin
        case ($urandom_range(0, 3))
          0: set_regs(8'd20, 8'd20, 8'd35, 10'd100);
          1: set_regs(8'($urandom_range(0, 6)), 8'($urandom_range(0, 4)),
                      8'($urandom_range(0, 255)), 10'($urandom_range(0, 40)));
          2: set_regs(8'd255, 8'd255, 8'd255, 10'd1023);
          default: set_regs(8'($urandom), 8'($urandom_range(1, 30)),
                            8'($urandom), 10'($urandom));
        endcase
      end
      if ($urandom_range(0, 9) == 0) begin
        send_column(5'($urandom), 1'($urandom));
        sent++;
      end else begin
        int n;
        n = $urandom_range(5, 60);
        random_job(n);
        sent += n + 1;
      end
    end

    // Drain and verdict.
    settle();
    if (fail_count == 0) begin
      $display("line_end_extension_tracker regression: pass");
    end else begin
      $display("line_end_extension_tracker regression: fail");
    end
    $finish;
  end

endmodule

FILE: line_end_extension_tracker.f
rtl/core/let_pkg.sv
rtl/core/let_datapath.sv
rtl/core/let_ctrl.sv
rtl/core/line_end_extension_tracker.sv
test/let_checker.sv
test/tb_top.sv
